// ----- rtl/pmre_pkg.sv -----
// Shared widths, register indexes and constants of the pole-mix response evaluator.
`timescale 1ns / 1ps
package pmre_pkg;

  // Port widths
  localparam int U_W      = 23;
  localparam int IN_TW    = 24;
  localparam int GAIN_W   = 16;
  localparam int Q_W      = 32;
  localparam int OUT_TW   = 64;
  localparam int NUM_REGS = 6;
  localparam int IDX_W    = 3;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_DRY   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POLE1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_POLE2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_POLE3 = 3'd3;
  localparam logic [IDX_W-1:0] REG_POLE4 = 3'd4;
  localparam logic [IDX_W-1:0] REG_FBK   = 3'd5;

  localparam logic signed [GAIN_W-1:0] POLE4_RST = 16'sd4096;

  // Fixed-point working widths
  localparam int FRAC   = 16;
  localparam int W2_W   = 30;
  localparam int W3_W   = 37;
  localparam int W4_W   = 44;
  localparam int P2R_W  = 32;
  localparam int P2I_W  = 24;
  localparam int P3R_W  = 34;
  localparam int P3I_W  = 39;
  localparam int P4R_W  = 47;
  localparam int P4I_W  = 42;
  localparam int NR_W   = 62;
  localparam int NI_W   = 57;
  localparam int MA_W   = 64;
  localparam int MB_W   = 48;
  localparam int MP_W   = 112;
  localparam int DEN_W  = 92;
  localparam int MAG_W  = 108;
  localparam int SHIFT  = 8;
  localparam int STEPS  = 32;

  // Pipeline layout
  localparam int NS       = 44;
  localparam int MUL_BASE = 6;
  localparam int DIV_BASE = 9;
  localparam int DS       = NS - DIV_BASE;

  localparam logic [Q_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [Q_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

// ----- rtl/pmre_mul.sv -----
// Two-stage signed 64x48 multiplier built from four narrow partial products.
`timescale 1ns / 1ps
module pmre_mul (
  input  logic                             clk_i,
  input  logic [1:0]                       en_i,
  input  logic signed [pmre_pkg::MA_W-1:0] a_i,
  input  logic signed [pmre_pkg::MB_W-1:0] b_i,
  output logic signed [pmre_pkg::MP_W-1:0] p_o
);

  logic [31:0]        al;
  logic signed [31:0] ah;
  logic [23:0]        bl;
  logic signed [23:0] bh;

  logic [55:0]        pll_d, pll_q;
  logic signed [56:0] phl_d, phl_q;
  logic signed [56:0] plh_d, plh_q;
  logic signed [55:0] phh_d, phh_q;
  logic signed [pmre_pkg::MP_W-1:0] p_d, p_q;

  // Split operands into low unsigned and high signed halves
  assign al = a_i[31:0];
  assign ah = a_i[63:32];
  assign bl = b_i[23:0];
  assign bh = b_i[47:24];

  assign pll_d = 56'(al) * 56'(bl);
  assign phl_d = $signed({{25{ah[31]}}, ah}) * $signed({33'b0, bl});
  assign plh_d = $signed({25'b0, al}) * $signed({{33{bh[23]}}, bh});
  assign phh_d = $signed({{24{ah[31]}}, ah}) * $signed({{32{bh[23]}}, bh});

  // Register partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pll_q <= pll_d;
      phl_q <= phl_d;
      plh_q <= plh_d;
      phh_q <= phh_d;
    end
  end

  // Align and sum partial products
  assign p_d = $signed({56'b0, pll_q})
             + (pmre_pkg::MP_W'(phl_q) <<< 32)
             + (pmre_pkg::MP_W'(plh_q) <<< 24)
             + (pmre_pkg::MP_W'(phh_q) <<< 56);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

// ----- rtl/pmre_cdiv.sv -----
// Pipelined restoring divider for the real and imaginary quotients, saturating to 32 bits.
`timescale 1ns / 1ps
module pmre_cdiv (
  input  logic                              clk_i,
  input  logic [pmre_pkg::DS-1:0]           en_i,
  input  logic signed [pmre_pkg::MP_W-1:0]  re_i,
  input  logic signed [pmre_pkg::MP_W-1:0]  im_i,
  input  logic [pmre_pkg::DEN_W-1:0]        den_i,
  input  logic                              zero_i,
  output logic [pmre_pkg::Q_W-1:0]          re_o,
  output logic [pmre_pkg::Q_W-1:0]          im_o,
  output logic                              zero_o
);

  localparam int STEPS = pmre_pkg::STEPS;
  localparam int DEN_W = pmre_pkg::DEN_W;
  localparam int MAG_W = pmre_pkg::MAG_W;
  localparam int Q_W   = pmre_pkg::Q_W;
  localparam int LO_W  = Q_W - pmre_pkg::SHIFT;

  // Magnitude stage
  logic signed [pmre_pkg::MP_W-1:0] num   [2];
  logic [MAG_W-1:0]                 mag_d [2];
  logic [MAG_W-1:0]                 mag_q [2];
  logic                             sgn_q [2];
  logic [DEN_W-1:0]                 dn0_q;
  logic                             zr0_q;

  // Step stages
  logic [DEN_W-1:0] rem_q  [STEPS][2];
  logic [Q_W-1:0]   low_q  [STEPS][2];
  logic [Q_W-1:0]   quo_q  [STEPS+1][2];
  logic             big_q  [STEPS+1][2];
  logic             neg_q  [STEPS+1][2];
  logic [DEN_W-1:0] den_q  [STEPS];
  logic             zero_q [STEPS+1];
  logic [DEN_W:0]   trial  [1:STEPS][2];
  logic             fit    [1:STEPS][2];

  logic [Q_W-1:0]   res_d [2];
  logic [Q_W-1:0]   res_q [2];
  logic             zo_q;

  assign num[0] = re_i;
  assign num[1] = im_i;

  // Take magnitudes of both numerators
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      mag_d[c] = num[c][pmre_pkg::MP_W-1] ? MAG_W'(-num[c]) : MAG_W'(num[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int c = 0; c < 2; c++) begin
        mag_q[c] <= mag_d[c];
        sgn_q[c] <= num[c][pmre_pkg::MP_W-1];
      end
      dn0_q <= den_i;
      zr0_q <= zero_i;
    end
  end

  // Trial subtract for each quotient bit
  always_comb begin
    for (int s = 1; s <= STEPS; s++) begin
      for (int c = 0; c < 2; c++) begin
        trial[s][c] = {rem_q[s-1][c], low_q[s-1][c][Q_W-1]};
        fit[s][c]   = trial[s][c] >= {1'b0, den_q[s-1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    // Flag quotients of 2^32 and more, seed the remainder with the high part
    if (en_i[1]) begin
      for (int c = 0; c < 2; c++) begin
        big_q[0][c] <= DEN_W'(mag_q[c][MAG_W-1:LO_W]) >= dn0_q;
        rem_q[0][c] <= DEN_W'(mag_q[c][MAG_W-1:LO_W]);
        low_q[0][c] <= {mag_q[c][LO_W-1:0], {pmre_pkg::SHIFT{1'b0}}};
        quo_q[0][c] <= '0;
        neg_q[0][c] <= sgn_q[c];
      end
      den_q[0]  <= dn0_q;
      zero_q[0] <= zr0_q;
    end
    // Advance one quotient bit per stage
    for (int s = 1; s <= STEPS; s++) begin
      if (en_i[s+1]) begin
        for (int c = 0; c < 2; c++) begin
          if (s < STEPS) begin
            rem_q[s][c] <= fit[s][c] ? DEN_W'(trial[s][c] - {1'b0, den_q[s-1]})
                                     : DEN_W'(trial[s][c]);
            low_q[s][c] <= {low_q[s-1][c][Q_W-2:0], 1'b0};
          end
          quo_q[s][c] <= {quo_q[s-1][c][Q_W-2:0], fit[s][c]};
          big_q[s][c] <= big_q[s-1][c];
          neg_q[s][c] <= neg_q[s-1][c];
        end
        if (s < STEPS) begin
          den_q[s] <= den_q[s-1];
        end
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  // Apply sign, saturate, force zero on a vanished denominator
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      if (zero_q[STEPS]) begin
        res_d[c] = '0;
      end else if (big_q[STEPS][c] || quo_q[STEPS][c][Q_W-1]) begin
        res_d[c] = neg_q[STEPS][c] ? pmre_pkg::SAT_NEG : pmre_pkg::SAT_POS;
      end else if (neg_q[STEPS][c]) begin
        res_d[c] = Q_W'(0) - quo_q[STEPS][c];
      end else begin
        res_d[c] = quo_q[STEPS][c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[pmre_pkg::DS-1]) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      zo_q     <= zero_q[STEPS];
    end
  end

  assign re_o   = res_q[0];
  assign im_o   = res_q[1];
  assign zero_o = zo_q;

endmodule

// ----- rtl/pole_mix_response_eval.sv -----
// Top level of the pole-mix filter complex frequency response evaluator.
`timescale 1ns / 1ps
// One frequency point enters per clock unless the pipeline is full with a stalled sink; a
// stalled output lets the pipeline close up its bubbles, so with a steady sink the rate is
// one point per cycle. The 44 register stages are: an omega capture stage, seven stages of
// power, mix and sum logic (two of them the split cross-product multipliers), one stage
// combining the cross products, a magnitude stage and a remainder seed stage, the 32-stage
// restoring divider (one quotient bit per stage, real and imaginary side by side) and the
// saturating output register. The user must write registers only while no point is in
// flight; the block itself does not enforce this.
module pole_mix_response_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pmre_pkg::IN_TW-1:0]    s_axis_tdata,   // omega[22:0], zero pad
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [pmre_pkg::OUT_TW-1:0]   m_axis_tdata,   // resp_real[31:0], resp_imag[63:32]
  output logic                          m_axis_tuser,   // denom_zero
  input  logic                          cfg_we_i,
  input  logic [pmre_pkg::IDX_W-1:0]    cfg_idx_i,
  input  logic [pmre_pkg::GAIN_W-1:0]   cfg_wdata_i
);

  localparam int NS = pmre_pkg::NS;

  logic signed [pmre_pkg::GAIN_W-1:0] gain_q [pmre_pkg::NUM_REGS];
  logic [NS-1:0] v_q, v_d, rdy;
  logic          run_q;
  logic          acc_in, acc_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q[pmre_pkg::REG_DRY]   <= '0;
      gain_q[pmre_pkg::REG_POLE1] <= '0;
      gain_q[pmre_pkg::REG_POLE2] <= '0;
      gain_q[pmre_pkg::REG_POLE3] <= '0;
      gain_q[pmre_pkg::REG_POLE4] <= pmre_pkg::POLE4_RST;
      gain_q[pmre_pkg::REG_FBK]   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pmre_pkg::REG_DRY:   gain_q[pmre_pkg::REG_DRY]   <= cfg_wdata_i;
        pmre_pkg::REG_POLE1: gain_q[pmre_pkg::REG_POLE1] <= cfg_wdata_i;
        pmre_pkg::REG_POLE2: gain_q[pmre_pkg::REG_POLE2] <= cfg_wdata_i;
        pmre_pkg::REG_POLE3: gain_q[pmre_pkg::REG_POLE3] <= cfg_wdata_i;
        pmre_pkg::REG_POLE4: gain_q[pmre_pkg::REG_POLE4] <= cfg_wdata_i;
        pmre_pkg::REG_FBK:   gain_q[pmre_pkg::REG_FBK]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage k loads when some stage from k up is empty or the output is taken
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      rdy[k] = m_axis_tready | ~&(v_q | ((NS'(1) << k) - NS'(1)));
    end
  end

  assign s_axis_tready = rdy[0] & run_q;
  assign acc_in        = s_axis_tvalid & s_axis_tready;
  assign acc_out       = m_axis_tvalid & m_axis_tready;

  always_comb begin
    v_d[0] = rdy[0] ? acc_in : v_q[0];
    for (int k = 1; k < NS; k++) begin
      v_d[k] = rdy[k] ? v_q[k-1] : v_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      run_q <= 1'b0;
    end else begin
      v_q   <= v_d;
      run_q <= 1'b1;
    end
  end

  // Stage 0: capture omega
  logic [pmre_pkg::U_W-1:0] u0_q, u1_q, u2_q, u3_q;
  always_ff @(posedge clk_i) begin
    if (rdy[0]) u0_q <= s_axis_tdata[pmre_pkg::U_W-1:0];
  end

  // Stage 1: w^2
  logic [2*pmre_pkg::U_W-1:0] uu;
  logic [pmre_pkg::W2_W-1:0]  w2_1_q, w2_2_q;
  assign uu = (2*pmre_pkg::U_W)'(u0_q) * (2*pmre_pkg::U_W)'(u0_q);
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      w2_1_q <= uu[pmre_pkg::FRAC +: pmre_pkg::W2_W];
      u1_q   <= u0_q;
    end
  end

  // Stage 2: w^3 and w^4
  logic [52:0] w2u;
  logic [59:0] w2w2;
  logic [pmre_pkg::W3_W-1:0] w3_q;
  logic [pmre_pkg::W4_W-1:0] w4_q;
  assign w2u  = 53'(w2_1_q) * 53'(u1_q);
  assign w2w2 = 60'(w2_1_q) * 60'(w2_1_q);
  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      w3_q   <= w2u[pmre_pkg::FRAC +: pmre_pkg::W3_W];
      w4_q   <= w2w2[pmre_pkg::FRAC +: pmre_pkg::W4_W];
      w2_2_q <= w2_1_q;
      u2_q   <= u1_q;
    end
  end

  // Stage 3: powers of p = 1 + jw
  logic signed [pmre_pkg::P2R_W-1:0] p2r_q;
  logic        [pmre_pkg::P2I_W-1:0] p2i_q;
  logic signed [pmre_pkg::P3R_W-1:0] p3r_q;
  logic signed [pmre_pkg::P3I_W-1:0] p3i_q;
  logic signed [pmre_pkg::P4R_W-1:0] p4r_q;
  logic signed [pmre_pkg::P4I_W-1:0] p4i_q;
  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      p2r_q <= 32'd65536 - {2'b0, w2_2_q};
      p2i_q <= {u2_q, 1'b0};
      p3r_q <= 34'd65536 - 34'd3 * {4'b0, w2_2_q};
      p3i_q <= 39'd3 * {16'b0, u2_q} - {2'b0, w3_q};
      p4r_q <= 47'd65536 - 47'd6 * {17'b0, w2_2_q} + {3'b0, w4_q};
      p4i_q <= {17'b0, u2_q, 2'b00} - {3'b0, w3_q, 2'b00};
      u3_q  <= u2_q;
    end
  end

  // Stage 4: weighted terms and denominator
  logic signed [62:0] ta_r_q;
  logic signed [49:0] tb_r_q;
  logic signed [47:0] tc_r_q;
  logic signed [57:0] ta_i_q;
  logic signed [54:0] tb_i_q;
  logic signed [40:0] tc_i_q;
  logic signed [39:0] td_i_q;
  logic signed [pmre_pkg::P4R_W-1:0] dr4_q, dr5_q;
  logic signed [pmre_pkg::P4I_W-1:0] di4_q, di5_q;
  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      ta_r_q <= gain_q[pmre_pkg::REG_DRY]   * p4r_q;
      tb_r_q <= gain_q[pmre_pkg::REG_POLE1] * p3r_q;
      tc_r_q <= gain_q[pmre_pkg::REG_POLE2] * p2r_q;
      ta_i_q <= gain_q[pmre_pkg::REG_DRY]   * p4i_q;
      tb_i_q <= gain_q[pmre_pkg::REG_POLE1] * p3i_q;
      tc_i_q <= gain_q[pmre_pkg::REG_POLE2] * $signed({1'b0, p2i_q});
      td_i_q <= gain_q[pmre_pkg::REG_POLE3] * $signed({1'b0, u3_q});
      dr4_q  <= p4r_q + (pmre_pkg::P4R_W'(gain_q[pmre_pkg::REG_FBK]) <<< 4);
      di4_q  <= p4i_q;
    end
  end

  // Stage 5: sum numerator terms, detect a vanished denominator
  logic signed [pmre_pkg::NR_W-1:0] nr_q;
  logic signed [pmre_pkg::NI_W-1:0] ni_q;
  logic [8:5] zero_q;
  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      nr_q <= pmre_pkg::NR_W'(ta_r_q) - pmre_pkg::NR_W'(tb_r_q) + pmre_pkg::NR_W'(tc_r_q)
            - (pmre_pkg::NR_W'(gain_q[pmre_pkg::REG_POLE3]) <<< pmre_pkg::FRAC)
            + (pmre_pkg::NR_W'(gain_q[pmre_pkg::REG_POLE4]) <<< pmre_pkg::FRAC);
      ni_q <= pmre_pkg::NI_W'(ta_i_q) - pmre_pkg::NI_W'(tb_i_q)
            + pmre_pkg::NI_W'(tc_i_q) - pmre_pkg::NI_W'(td_i_q);
      dr5_q     <= dr4_q;
      di5_q     <= di4_q;
      zero_q[5] <= (dr4_q == '0) && (di4_q == '0);
    end
  end

  // Stages 6 and 7: cross products
  logic signed [pmre_pkg::MP_W-1:0] nrdr, nidi, nidr, nrdi, drdr, didi;
  logic signed [pmre_pkg::MA_W-1:0] nr_a, ni_a, dr_a, di_a;
  logic signed [pmre_pkg::MB_W-1:0] dr_b, di_b;
  assign nr_a = pmre_pkg::MA_W'(nr_q);
  assign ni_a = pmre_pkg::MA_W'(ni_q);
  assign dr_a = pmre_pkg::MA_W'(dr5_q);
  assign di_a = pmre_pkg::MA_W'(di5_q);
  assign dr_b = pmre_pkg::MB_W'(dr5_q);
  assign di_b = pmre_pkg::MB_W'(di5_q);

  pmre_mul u_mul_nrdr (.clk_i, .en_i(rdy[pmre_pkg::MUL_BASE+1:pmre_pkg::MUL_BASE]),
                       .a_i(nr_a), .b_i(dr_b), .p_o(nrdr));
  pmre_mul u_mul_nidi (.clk_i, .en_i(rdy[pmre_pkg::MUL_BASE+1:pmre_pkg::MUL_BASE]),
                       .a_i(ni_a), .b_i(di_b), .p_o(nidi));
  pmre_mul u_mul_nidr (.clk_i, .en_i(rdy[pmre_pkg::MUL_BASE+1:pmre_pkg::MUL_BASE]),
                       .a_i(ni_a), .b_i(dr_b), .p_o(nidr));
  pmre_mul u_mul_nrdi (.clk_i, .en_i(rdy[pmre_pkg::MUL_BASE+1:pmre_pkg::MUL_BASE]),
                       .a_i(nr_a), .b_i(di_b), .p_o(nrdi));
  pmre_mul u_mul_drdr (.clk_i, .en_i(rdy[pmre_pkg::MUL_BASE+1:pmre_pkg::MUL_BASE]),
                       .a_i(dr_a), .b_i(dr_b), .p_o(drdr));
  pmre_mul u_mul_didi (.clk_i, .en_i(rdy[pmre_pkg::MUL_BASE+1:pmre_pkg::MUL_BASE]),
                       .a_i(di_a), .b_i(di_b), .p_o(didi));

  always_ff @(posedge clk_i) begin
    if (rdy[6]) zero_q[6] <= zero_q[5];
    if (rdy[7]) zero_q[7] <= zero_q[6];
  end

  // Stage 8: combine into numerators and |D|^2
  logic signed [pmre_pkg::MP_W-1:0] re_q, im_q, den_sum;
  logic [pmre_pkg::DEN_W-1:0]       den_q;
  assign den_sum = drdr + didi;
  always_ff @(posedge clk_i) begin
    if (rdy[8]) begin
      re_q      <= nrdr + nidi;
      im_q      <= nidr - nrdi;
      den_q     <= den_sum[pmre_pkg::DEN_W-1:0];
      zero_q[8] <= zero_q[7];
    end
  end

  // Stages 9 to 43: divide, saturate, output register
  pmre_cdiv u_cdiv (
    .clk_i,
    .en_i  (rdy[NS-1:pmre_pkg::DIV_BASE]),
    .re_i  (re_q),
    .im_i  (im_q),
    .den_i (den_q),
    .zero_i(zero_q[8]),
    .re_o  (m_axis_tdata[pmre_pkg::Q_W-1:0]),
    .im_o  (m_axis_tdata[pmre_pkg::OUT_TW-1:pmre_pkg::Q_W]),
    .zero_o(m_axis_tuser)
  );

  assign m_axis_tvalid = v_q[NS-1];

  // A zero-denominator result carries zero data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("denom_zero result with nonzero data");

  // A full pipeline with a stalled sink takes no new transfer
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&v_q) && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted into a full stalled pipeline");

  // Items in flight change only by transfers in and out
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> $countones(v_q) ==
      $past($countones(v_q)) + 32'($past(acc_in)) - 32'($past(acc_out)))
    else $error("item lost or duplicated in pipeline");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the pole-mix filter frequency response evaluator.
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
  } resp_t;

  typedef struct {
    logic [22:0] omega;
    logic        has_exp;
    resp_t       exp_resp;
  } vec_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [pmre_pkg::IN_TW-1:0]    s_axis_tdata = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [pmre_pkg::OUT_TW-1:0]   m_axis_tdata;
  logic                          m_axis_tuser;
  logic                          cfg_we_i = 1'b0;
  logic [pmre_pkg::IDX_W-1:0]    cfg_idx_i = '0;
  logic [pmre_pkg::GAIN_W-1:0]   cfg_wdata_i = '0;

  logic signed [15:0] gain_q[pmre_pkg::NUM_REGS];
  resp_t              pending_resp[$];
  int                 fail_cnt = 0;
  bit                 sink_idle_en = 1'b1;

  pole_mix_response_eval u_top (.*);

  // Clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Saturate a wide signed quotient to 32 bits
  function automatic logic [31:0] sat32(logic signed [159:0] q);
    if (q > 160'sd2147483647) return pmre_pkg::SAT_POS;
    if (q < -160'sd2147483648) return pmre_pkg::SAT_NEG;
    return q[31:0];
  endfunction

  // Compute the expected response for one frequency point
  function automatic resp_t eval_response(logic [22:0] om);
    logic signed [159:0] u, w2, w3, w4, a, b, c, d, e, k;
    logic signed [159:0] p2r, p2i, p3r, p3i, p4r, p4i, nr, ni, dr, di, den, re, im;
    resp_t r;
    u  = om;
    w2 = (u * u) >>> 16;
    w3 = (w2 * u) >>> 16;
    w4 = (w2 * w2) >>> 16;
    a = gain_q[pmre_pkg::REG_DRY];   b = gain_q[pmre_pkg::REG_POLE1];
    c = gain_q[pmre_pkg::REG_POLE2]; d = gain_q[pmre_pkg::REG_POLE3];
    e = gain_q[pmre_pkg::REG_POLE4]; k = gain_q[pmre_pkg::REG_FBK];
    p2r = 65536 - w2;           p2i = 2 * u;
    p3r = 65536 - 3 * w2;       p3i = 3 * u - w3;
    p4r = 65536 - 6 * w2 + w4;  p4i = 4 * u - 4 * w3;
    nr = a * p4r - b * p3r + c * p2r - d * 65536 + e * 65536;
    ni = a * p4i - b * p3i + c * p2i - d * u;
    dr = p4r + k * 16;
    di = p4i;
    if (dr == 0 && di == 0) begin
      r.re = '0; r.im = '0; r.dz = 1'b1;
      return r;
    end
    den = dr * dr + di * di;
    re = ((nr * dr + ni * di) * 256) / den;
    im = ((ni * dr - nr * di) * 256) / den;
    r.re = sat32(re); r.im = sat32(im); r.dz = 1'b0;
    return r;
  endfunction

  // Pick a random gap, mostly short and a few long
  function automatic int rand_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 0;
    if (sel < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random omega, mostly in range with some full-width values
  function automatic logic [22:0] rand_omega();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 23'($urandom_range(0, 6553600));
    if (sel < 8) return 23'($urandom_range(0, 131072));
    return 23'($urandom());
  endfunction

  task automatic write_reg(logic [pmre_pkg::IDX_W-1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx < pmre_pkg::NUM_REGS) gain_q[idx] = val;
  endtask

  // Wait until all responses are in, then let the pipeline drain
  task automatic drain();
    while (pending_resp.size() != 0) @(negedge clk_i);
    repeat (pmre_pkg::NS + 10) @(negedge clk_i);
  endtask

  task automatic send_point(logic [22:0] om, bit has_exp, resp_t exp_resp);
    resp_t pred;
    int gap;
    gap = rand_gap();
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    pred = eval_response(om);
    if (has_exp && pred != exp_resp) begin
      $error("directed row omega=%0d: predictor %h, table %h", om, pred, exp_resp);
      fail_cnt++;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, om};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_resp = {pending_resp, pred};
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  // Output side: random stalls unless disabled for the phase, check each transfer
  always @(negedge clk_i) begin
    if (sink_idle_en) m_axis_tready <= ($urandom_range(0, 99) < 70);
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    resp_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.re = m_axis_tdata[31:0];
      got.im = m_axis_tdata[63:32];
      got.dz = m_axis_tuser;
      if (pending_resp.size() == 0) begin
        $error("unexpected response transfer %h", got);
        fail_cnt++;
      end else begin
        want = pending_resp.pop_front();
        if (got.re !== want.re) begin
          $error("resp_real expected %h actual %h", want.re, got.re); fail_cnt++;
        end
        if (got.im !== want.im) begin
          $error("resp_imag expected %h actual %h", want.im, got.im); fail_cnt++;
        end
        if (got.dz !== want.dz) begin
          $error("denom_zero expected %b actual %b", want.dz, got.dz); fail_cnt++;
        end
      end
    end
  end

  // Timeout
  initial begin
    #5ms;
    $display("testbench failed");
    $finish;
  end

  initial begin
    vec_t        dir_tbl[$];
    vec_t        v;
    resp_t       zr;
    resp_t       one_r;
    resp_t       sat_r;
    logic [22:0] oms[8];
    int          phase, n;
    oms = '{23'd1, 23'd65536, 23'd6553600, 23'h7FFFFF,
            23'h400000, 23'd32768, 23'h2AAAAA, 23'h555555};
    gain_q = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, pmre_pkg::POLE4_RST, 16'sd0};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed rows: after reset H = 1/p^4; at w = 0 this is exactly 1.0
    zr    = '{re: 32'h0, im: 32'h0, dz: 1'b0};
    one_r = '{re: 32'h0010_0000, im: 32'h0, dz: 1'b0};
    v = '{omega: 23'd0, has_exp: 1'b1, exp_resp: one_r};
    dir_tbl = {dir_tbl, v};
    foreach (oms[i]) begin
      v = '{omega: oms[i], has_exp: 1'b0, exp_resp: zr};
      dir_tbl = {dir_tbl, v};
    end
    foreach (dir_tbl[i]) send_point(dir_tbl[i].omega, dir_tbl[i].has_exp,
                                    dir_tbl[i].exp_resp);
    idle_input();
    drain();

    // Zero denominator: k = -1.0 with w = 0 cancels p^4 exactly
    write_reg(pmre_pkg::REG_FBK, 16'hF000);
    zr = '{re: 32'h0, im: 32'h0, dz: 1'b1};
    send_point(23'd0, 1'b1, zr);
    send_point(23'd1, 1'b0, zr);
    idle_input();
    drain();

    // Extreme gains: saturation on a tiny denominator
    write_reg(pmre_pkg::REG_DRY, 16'h7FFF);   write_reg(pmre_pkg::REG_POLE1, 16'h8000);
    write_reg(pmre_pkg::REG_POLE2, 16'h7FFF); write_reg(pmre_pkg::REG_POLE3, 16'h8000);
    write_reg(pmre_pkg::REG_POLE4, 16'h7FFF); write_reg(pmre_pkg::REG_FBK, 16'hF001);
    sat_r = '{re: pmre_pkg::SAT_POS, im: 32'h0, dz: 1'b0};
    send_point(23'd0, 1'b1, sat_r);
    for (int i = 0; i < 6; i++) send_point(rand_omega(), 1'b0, zr);
    idle_input();
    drain();
    // Index past the register list is ignored
    write_reg(3'd7, 16'h1234);
    write_reg(pmre_pkg::REG_DRY, 16'h8000);   write_reg(pmre_pkg::REG_POLE2, 16'h8000);
    write_reg(pmre_pkg::REG_POLE4, 16'h8000); write_reg(pmre_pkg::REG_FBK, 16'h7FFF);
    for (int i = 0; i < 6; i++) send_point(rand_omega(), 1'b0, zr);
    idle_input();
    drain();

    // Random phases with random register settings
    for (phase = 0; phase < 12; phase++) begin
      for (int r = 0; r < pmre_pkg::NUM_REGS; r++) begin
        write_reg(pmre_pkg::IDX_W'(r), 16'($urandom()));
      end
      sink_idle_en = (phase % 4 != 3);
      n = 128;
      for (int i = 0; i < n; i++) begin
        send_point(rand_omega(), 1'b0, zr);
        if (i == 60 && phase == 2) begin
          idle_input();
          while (pending_resp.size() != 0) @(negedge clk_i);
        end
      end
      idle_input();
      drain();
    end

    if (fail_cnt == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
